// File: hw/rtl/pctd_pkg.sv
// shared types and constants of the percent escape decoder
package pctd_pkg;

    localparam logic [15:0] PCT_CHAR = 16'h0025;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // slot positions inside one bundle
    localparam logic [1:0] SLOT_0 = 2'd0;
    localparam logic [1:0] SLOT_1 = 2'd1;

    // up to three decoded words produced by one input word
    typedef struct packed {
        logic [2:0][15:0] chars;
        logic [1:0]       last_idx;
        logic             end_only;
        logic             last;
    } pctd_bundle_t;

endpackage

// File: hw/rtl/pctd_front.sv
// front: escape tracking, turns each accepted input word into a bundle of results, pushed only when it holds any
module pctd_front import pctd_pkg::*; #(
    parameter int CHAR_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         accept,
    input  logic [15:0]  in_char,
    input  logic         in_last,
    output logic         push,
    output pctd_bundle_t bundle
);

    localparam int          EFF_BITS  = (CHAR_BITS < 16) ? CHAR_BITS : 16;
    localparam logic [15:0] CHAR_MASK = 16'((33'd1 << EFF_BITS) - 33'd1);

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_PCT  = 3'b010,
        PH_HEX  = 3'b100
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [6:0] held_reg, held_next;

    logic [15:0] c;
    logic        c_hex;
    logic        c_pct;
    logic [7:0]  dec_val;
    logic [47:0] slots;
    logic [1:0]  n;
    logic        end_only;

    function automatic logic is_hex(input logic [15:0] ch);
        logic r;
        r = 1'b0;
        if (ch[15:7] == 9'd0) begin
            r = ch[6:0] inside {[7'h30:7'h39], [7'h41:7'h46], [7'h61:7'h66]};
        end
        return r;
    endfunction

    function automatic logic [3:0] hex_val(input logic [6:0] ch);
        logic [3:0] r;
        if (ch[6:4] == 3'h3) begin
            r = ch[3:0];
        end else begin
            r = ch[3:0] + 4'd9;
        end
        return r;
    endfunction

    function automatic logic [47:0] put_slot(input logic [47:0] s, input logic [1:0] idx,
                                             input logic [15:0] x);
        logic [47:0] r;
        r = s;
        case (idx)
            SLOT_0:  r[15:0]  = x;
            SLOT_1:  r[31:16] = x;
            default: r[47:32] = x;
        endcase
        return r;
    endfunction

    assign c       = in_char & CHAR_MASK;
    assign c_hex   = is_hex(c);
    assign c_pct   = (c == PCT_CHAR);
    assign dec_val = {hex_val(held_reg), hex_val(c[6:0])};

    always_comb
    begin
        phase_next = phase_reg;
        held_next  = held_reg;
        slots      = '0;
        n          = 2'd0;
        end_only   = 1'b0;

        case (phase_reg)
            PH_PCT:
            begin
                if (c_hex) begin
                    held_next  = c[6:0];
                    phase_next = PH_HEX;
                end else begin
                    slots = put_slot(slots, n, PCT_CHAR);
                    n     = n + 2'd1;
                    if (c_pct) begin
                        phase_next = PH_PCT;
                    end else begin
                        slots      = put_slot(slots, n, c);
                        n          = n + 2'd1;
                        phase_next = PH_IDLE;
                    end
                end
            end
            PH_HEX:
            begin
                phase_next = PH_IDLE;
                held_next  = 7'd0;
                if (c_hex) begin
                    // %00 is dropped
                    if (dec_val != 8'd0) begin
                        slots = put_slot(slots, n, {8'd0, dec_val});
                        n     = n + 2'd1;
                    end
                end else begin
                    slots = put_slot(slots, n, PCT_CHAR);
                    n     = n + 2'd1;
                    slots = put_slot(slots, n, {9'd0, held_reg});
                    n     = n + 2'd1;
                    if (c_pct) begin
                        phase_next = PH_PCT;
                    end else begin
                        slots = put_slot(slots, n, c);
                        n     = n + 2'd1;
                    end
                end
            end
            default:
            begin
                if (c_pct) begin
                    phase_next = PH_PCT;
                end else begin
                    slots      = put_slot(slots, n, c);
                    n          = n + 2'd1;
                    phase_next = PH_IDLE;
                end
            end
        endcase

        // flush a pending escape at end of string
        if (in_last) begin
            if (phase_next == PH_PCT) begin
                slots = put_slot(slots, n, PCT_CHAR);
                n     = n + 2'd1;
            end else if (phase_next == PH_HEX) begin
                slots = put_slot(slots, n, PCT_CHAR);
                n     = n + 2'd1;
                slots = put_slot(slots, n, {9'd0, held_next});
                n     = n + 2'd1;
            end
            phase_next = PH_IDLE;
            held_next  = 7'd0;
            if (n == 2'd0) begin
                end_only = 1'b1;
                n        = 2'd1;
            end
        end
    end

    assign push              = accept && (n != 2'd0);
    assign bundle.chars      = slots;
    assign bundle.last_idx   = n - 2'd1;
    assign bundle.end_only   = end_only;
    assign bundle.last       = in_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= PH_IDLE;
            held_reg  <= 7'd0;
        end else if (accept) begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

endmodule

// File: hw/rtl/pctd_queue.sv
// short bundle queue between front and back
module pctd_queue import pctd_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  pctd_bundle_t push_data,
    input  logic         pop,
    output pctd_bundle_t head,
    output logic         head_valid,
    output logic         full
);

    pctd_bundle_t         entries [QUEUE_DEPTH];
    logic [QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]    count_reg, count_next;
    logic                 do_push;
    logic                 do_pop;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entries[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: hw/rtl/pctd_back.sv
// back: walks the slots of the head bundle into the output register
module pctd_back import pctd_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  pctd_bundle_t head,
    input  logic         head_valid,
    output logic         pop,
    output logic         out_valid,
    input  logic         out_stall,
    output logic [15:0]  out_char,
    output logic         has_char,
    output logic         out_last
);

    logic [1:0]  idx_reg, idx_next;
    logic        valid_reg, valid_next;
    logic [15:0] char_reg;
    logic        has_reg;
    logic        last_reg;
    logic        load;
    logic        at_end;
    logic [15:0] sel_char;

    always_comb
    begin
        case (idx_reg)
            SLOT_0:  sel_char = head.chars[0];
            SLOT_1:  sel_char = head.chars[1];
            default: sel_char = head.chars[2];
        endcase
    end

    assign load   = head_valid && (!valid_reg || !out_stall);
    assign at_end = (idx_reg == head.last_idx);
    assign pop    = load && at_end;

    always_comb
    begin
        idx_next = idx_reg;
        if (load) begin
            idx_next = at_end ? SLOT_0 : idx_reg + 2'd1;
        end
        if (load) begin
            valid_next = 1'b1;
        end else if (!out_stall) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg   <= SLOT_0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            char_reg <= head.end_only ? 16'd0 : sel_char;
            has_reg  <= !head.end_only;
            last_reg <= head.last && at_end;
        end
    end

    assign out_valid = valid_reg;
    assign out_char  = char_reg;
    assign has_char  = has_reg;
    assign out_last  = last_reg;

endmodule

// File: hw/rtl/percent_escape_decoder_unit.sv
// percent escape decoder: top level joining front, queue and back
// path: a word's first result is written into the bundle queue, then loaded into the output register
// throughput: one input word per cycle while the queue is not full; the back emits a word's results slot by slot
// words that yield nothing (a '%' or first hex digit) push no bundle to the back at all
// the four-entry bundle queue absorbs bursts; in_stall rises only when it is full
// reset: asynchronous, active low; clears escape state, queue pointers and output valid
module percent_escape_decoder_unit import pctd_pkg::*; #(
    parameter int CHAR_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] in_char,
    input  logic        in_last,
    // output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] out_char,
    output logic        has_char,
    output logic        out_last
);

    logic         accept;
    logic         push;
    pctd_bundle_t push_bundle;
    pctd_bundle_t head;
    logic         head_valid;
    logic         pop;
    logic         queue_full;

    // a word is taken whenever the queue has room, independent of the output side
    assign in_stall = queue_full;
    assign accept   = in_valid && !queue_full;

    // front classifies each word against the pending escape and builds its bundle
    pctd_front #(
        .CHAR_BITS (CHAR_BITS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_char (in_char),
        .in_last (in_last),
        .push    (push),
        .bundle  (push_bundle)
    );

    // decouples the front from output back-pressure
    pctd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_bundle),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid),
        .full       (queue_full)
    );

    // back emits one decoded word per cycle from the head bundle while the output is not stalled
    pctd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_char   (out_char),
        .has_char   (has_char),
        .out_last   (out_last)
    );

endmodule
